// ===== src/hxfcp_pkg.sv =====
// Shared types and constants for the header/XOR frame command parser.
`default_nettype none

package hxfcp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Reset values of the configuration registers
  localparam logic [ByteW-1:0] FirstHdrRst  = 8'h55;
  localparam logic [ByteW-1:0] SecondHdrRst = 8'hAA;
  localparam logic [ByteW-1:0] LedFuncRst   = 8'h06;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_HDR  = 2'd0,
    CFG_SECOND_HDR = 2'd1,
    CFG_LED_FUNC   = 2'd2
  } cfg_idx_e;

  // Frame byte position: which byte is expected next
  typedef enum logic [2:0] {
    POS_HDR1  = 3'd0,
    POS_HDR2  = 3'd1,
    POS_FREE  = 3'd2,
    POS_FUNC  = 3'd3,
    POS_LED   = 3'd4,
    POS_STATE = 3'd5,
    POS_CSUM  = 3'd6
  } pos_e;

  // Frame status reported per completed frame
  typedef enum logic [1:0] {
    ST_LED_CMD  = 2'd0,
    ST_CSUM_ERR = 2'd1,
    ST_OTHER    = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] first_header;
    logic [ByteW-1:0] second_header;
    logic [ByteW-1:0] led_function_code;
  } cfg_t;

  typedef struct packed {
    status_e          frame_status;
    logic [ByteW-1:0] led_index;
    logic             led_on;
  } result_t;

endpackage

`default_nettype wire

// ===== src/hxfcp_cfg_regs.sv =====
// Configuration register file for the frame parser.
`default_nettype none

module hxfcp_cfg_regs
  import hxfcp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header      <= FirstHdrRst;
      cfg_q.second_header     <= SecondHdrRst;
      cfg_q.led_function_code <= LedFuncRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_HDR:  cfg_q.first_header      <= cfg_data_i;
        CFG_SECOND_HDR: cfg_q.second_header     <= cfg_data_i;
        CFG_LED_FUNC:   cfg_q.led_function_code <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/hxfcp_parser.sv =====
// Frame tracking state and per-byte decode of the frame parser.
`default_nettype none

module hxfcp_parser
  import hxfcp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  emit_o,
  output result_t               res_o
);

  pos_e             pos_q, pos_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [ByteW-1:0] func_q, func_d;
  logic [ByteW-1:0] led_q, led_d;
  logic [ByteW-1:0] state_q, state_d;

  // Next state for one byte; a result comes out on the checksum byte
  always_comb begin
    pos_d   = pos_q;
    xor_d   = xor_q;
    func_d  = func_q;
    led_d   = led_q;
    state_d = state_q;
    emit_o  = 1'b0;
    res_o.frame_status = ST_OTHER;
    res_o.led_index    = '0;
    res_o.led_on       = 1'b0;
    case (pos_q)
      POS_HDR2: begin
        if (byte_i == cfg_i.second_header) begin
          xor_d = xor_q ^ byte_i;
          pos_d = POS_FREE;
        end else begin
          pos_d = POS_HDR1;
        end
      end
      POS_FREE: begin
        xor_d = xor_q ^ byte_i;
        pos_d = POS_FUNC;
      end
      POS_FUNC: begin
        func_d = byte_i;
        xor_d  = xor_q ^ byte_i;
        pos_d  = POS_LED;
      end
      POS_LED: begin
        led_d = byte_i;
        xor_d = xor_q ^ byte_i;
        pos_d = POS_STATE;
      end
      POS_STATE: begin
        state_d = byte_i;
        xor_d   = xor_q ^ byte_i;
        pos_d   = POS_CSUM;
      end
      POS_CSUM: begin
        emit_o = 1'b1;
        if (xor_q != byte_i) begin
          res_o.frame_status = ST_CSUM_ERR;
        end else if (func_q == cfg_i.led_function_code) begin
          res_o.frame_status = ST_LED_CMD;
          res_o.led_index    = led_q;
          res_o.led_on       = |state_q;
        end
        xor_d = '0;
        pos_d = POS_HDR1;
      end
      default: begin
        // Header search; unused codes behave as this position
        if (byte_i == cfg_i.first_header) begin
          xor_d = byte_i;
          pos_d = POS_HDR2;
        end else begin
          pos_d = POS_HDR1;
        end
      end
    endcase
  end

  // State registers, advanced once per consumed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_HDR1;
      xor_q   <= '0;
      func_q  <= '0;
      led_q   <= '0;
      state_q <= '0;
    end else if (step_i) begin
      pos_q   <= pos_d;
      xor_q   <= xor_d;
      func_q  <= func_d;
      led_q   <= led_d;
      state_q <= state_d;
    end
  end

  // A completed frame always restarts the header search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pos_q == POS_CSUM |=> pos_q == POS_HDR1 && xor_q == '0)
    else $error("parser did not restart after checksum byte");

  // Second header mismatch drops back without keeping the byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pos_q == POS_HDR2 && byte_i != cfg_i.second_header |=> pos_q == POS_HDR1)
    else $error("second header mismatch not handled");

  // Only an LED command carries LED fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_o && res_o.frame_status != ST_LED_CMD |-> res_o.led_index == '0 && !res_o.led_on)
    else $error("LED fields set on a non-LED result");

endmodule

`default_nettype wire

// ===== src/header_xor_frame_command_parser_top.sv =====
// Top level of the header/XOR frame command parser.
//
//  Channel | Signals                                                     | Direction
//  rx      | rx_valid_i, rx_stall_o, rx_byte_i                           | byte in
//  out     | out_valid_o, out_stall_i, frame_status_o, led_index_o, led_on_o | result out
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i           | register write
//
// One byte per cycle sustained: an input register feeds the frame decode,
// which writes the result register. A checksum byte's result is written to the
// result register as the byte leaves the input register. Reset clears the
// frame state and loads the register defaults. A stalled result register
// holds back only a checksum byte; other bytes keep flowing while a result waits.
`default_nettype none

module header_xor_frame_command_parser_top
  import hxfcp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               rx_valid_i,
  output logic                    rx_stall_o,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [1:0]              frame_status_o,
  output logic [ByteW-1:0]        led_index_o,
  output logic                    led_on_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          res_q;
  result_t          parse_res;
  logic             parse_emit;
  logic             out_free;
  logic             step;

  hxfcp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hxfcp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (step),
    .byte_i (in_byte_q),
    .emit_o (parse_emit),
    .res_o  (parse_res)
  );

  // Flow control: a byte leaves the input register unless its result is blocked
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!parse_emit || out_free);
  assign rx_stall_o = in_valid_q && !step;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!rx_stall_o) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_valid_i && !rx_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && parse_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && parse_emit) begin
      res_q <= parse_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_status_o = res_q.frame_status;
  assign led_index_o    = res_q.led_index;
  assign led_on_o       = res_q.led_on;

  // An emitted result always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && parse_emit |=> out_valid_q)
    else $error("emitted result lost");

  // A waiting result is never overwritten by the next frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && in_valid_q && parse_emit |-> !step && rx_stall_o)
    else $error("checksum byte consumed while result stalled");

  // Bytes that make no result are never held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !parse_emit |-> step && !rx_stall_o)
    else $error("non-final byte stalled");

endmodule

`default_nettype wire
